// ===== sv/fcsd_pkg.sv =====
// Shared types and constants for the friend code checksum and digit unit.
// Holds the controller state encoding, the command and status structs and
// the SHA-1 constants. Depends on nothing.
package fcsd_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned SumW    = 7;
  localparam int unsigned CodeW   = IdW + SumW;
  localparam int unsigned Digits  = 12;
  localparam int unsigned BcdW    = 4 * Digits;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned CntW    = 7;

  localparam logic [1:0] PH_CH   = 2'd0;
  localparam logic [1:0] PH_PAR1 = 2'd1;
  localparam logic [1:0] PH_MAJ  = 2'd2;
  localparam logic [1:0] PH_PAR2 = 2'd3;

  localparam logic [31:0] RoundK [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;

  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] LenWord = 32'd32;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HASH = 6'b000010,
    ST_FIN  = 6'b000100,
    ST_CONV = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_NOID = 6'b100000
  } state_e;

  typedef struct packed {
    logic       load;
    logic       round;
    logic [1:0] phase;
    logic       finish;
    logic       dabble;
    logic       shift_out;
  } cmd_t;

  typedef struct packed {
    logic id_zero;
  } status_t;

endpackage

// ===== sv/fcsd_datapath.sv =====
// Datapath: SHA-1 round unit with a sliding message schedule, checksum
// capture, binary to BCD shift-and-add-3 converter and digit shifter.
// Depends on fcsd_pkg; driven by fcsd_ctrl commands.
module fcsd_datapath (
  input  logic                         clk_i,
  input  logic [31:0]                  principal_id_i,
  input  fcsd_pkg::cmd_t               cmd_i,
  output fcsd_pkg::status_t            status_o,
  output logic [3:0]                   digit_o,
  output logic [6:0]                   checksum_o,
  output logic [38:0]                  friend_code_o
);
  import fcsd_pkg::*;

  logic [31:0]      w_q [16];
  logic [31:0]      a_q, b_q, c_q, d_q, e_q;
  logic [CodeW-1:0] code_q;
  logic [CodeW-1:0] bin_q;
  logic [BcdW-1:0]  bcd_q;

  logic [31:0]     f;
  logic [31:0]     t;
  logic [31:0]     w_new;
  logic [31:0]     h0_sum;
  logic [BcdW-1:0] bcd_adj;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  always_comb begin
    case (cmd_i.phase) inside
      PH_CH:            f = (b_q & c_q) | (~b_q & d_q);
      PH_MAJ:           f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      PH_PAR1, PH_PAR2: f = b_q ^ c_q ^ d_q;
      default:          f = b_q ^ c_q ^ d_q;
    endcase
  end

  assign t      = rotl(a_q, 5) + f + e_q + RoundK[cmd_i.phase] + w_q[0];
  assign w_new  = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
  assign h0_sum = H0Init + a_q;

  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 2; i < 15; i++) begin
        w_q[i] <= '0;
      end
      w_q[0]  <= {principal_id_i[7:0], principal_id_i[15:8],
                  principal_id_i[23:16], principal_id_i[31:24]};
      w_q[1]  <= PadWord;
      w_q[15] <= LenWord;
      a_q     <= H0Init;
      b_q     <= H1Init;
      c_q     <= H2Init;
      d_q     <= H3Init;
      e_q     <= H4Init;
      code_q  <= {{SumW{1'b0}}, principal_id_i};
      bin_q   <= '0;
      bcd_q   <= '0;
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
      a_q     <= t;
      b_q     <= a_q;
      c_q     <= rotl(b_q, 30);
      d_q     <= c_q;
      e_q     <= d_q;
    end else if (cmd_i.finish) begin
      code_q <= {h0_sum[31:25], code_q[IdW-1:0]};
      bin_q  <= {h0_sum[31:25], code_q[IdW-1:0]};
    end else if (cmd_i.dabble) begin
      bcd_q <= {bcd_adj[BcdW-2:0], bin_q[CodeW-1]};
      bin_q <= {bin_q[CodeW-2:0], 1'b0};
    end else if (cmd_i.shift_out) begin
      bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
    end
  end

  assign status_o.id_zero = (principal_id_i == '0);
  assign digit_o          = bcd_q[BcdW-1 -: 4];
  assign checksum_o       = code_q[CodeW-1 -: SumW];
  assign friend_code_o    = code_q;

endmodule

// ===== sv/fcsd_ctrl.sv =====
// Controller: sequences load, 80 hash rounds, checksum capture, 39 BCD
// steps and 12 digit items. Depends on fcsd_pkg; drives fcsd_datapath.
module fcsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              last_o,
  output logic              no_identity_o,
  input  fcsd_pkg::status_t status_i,
  output fcsd_pkg::cmd_t    cmd_o
);
  import fcsd_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic in_fire, out_fire, cnt_end;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    cnt_end = 1'b0;
    if (cnt_q < CntW'(20)) begin
      cmd_o.phase = PH_CH;
    end else if (cnt_q < CntW'(40)) begin
      cmd_o.phase = PH_PAR1;
    end else if (cnt_q < CntW'(60)) begin
      cmd_o.phase = PH_MAJ;
    end else begin
      cmd_o.phase = PH_PAR2;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = status_i.id_zero ? ST_NOID : ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.round = 1'b1;
        cnt_end     = (cnt_q == CntW'(Rounds - 1));
        cnt_d       = cnt_end ? '0 : cnt_q + 1'b1;
        if (cnt_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        cnt_d        = '0;
        state_d      = ST_CONV;
      end
      ST_CONV: begin
        cmd_o.dabble = 1'b1;
        cnt_end      = (cnt_q == CntW'(CodeW - 1));
        cnt_d        = cnt_end ? '0 : cnt_q + 1'b1;
        if (cnt_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          cmd_o.shift_out = 1'b1;
          cnt_end         = (cnt_q == CntW'(Digits - 1));
          cnt_d           = cnt_end ? '0 : cnt_q + 1'b1;
          if (cnt_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_NOID: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT) || (state_q == ST_NOID);
  assign no_identity_o = (state_q == ST_NOID);
  assign last_o        = (state_q == ST_NOID) ||
                         ((state_q == ST_EMIT) && (cnt_q == CntW'(Digits - 1)));

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_hash_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HASH) && (cnt_q == CntW'(Rounds - 1)) |=> (state_q == ST_FIN))
    else $error("hash did not end after the last round");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_o |=> in_ready_o)
    else $error("not idle after last item");

  a_noid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    no_identity_o |-> last_o && out_valid_o)
    else $error("no-identity item not flagged last");

endmodule

// ===== sv/friend_code_sha1_digits_unit.sv =====
// Friend code unit: takes a 32-bit principal id, computes a 7-bit SHA-1
// checksum and emits the 39-bit friend code as 12 decimal digit items,
// most significant first. Each id takes a load step, 80 hash rounds (one
// SHA-1 round per cycle in the shared round unit), a checksum step and 39
// BCD conversion steps, then 12 digit items at one per cycle while the
// output is ready. An id of zero yields a single item flagged no_identity
// and last, valid in the cycle after acceptance. A new id is taken only
// after the last item of the previous one has left.
module friend_code_sha1_digits_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] principal_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  digit_o,
  output logic        last_o,
  output logic        no_identity_o,
  output logic [6:0]  checksum_o,
  output logic [38:0] friend_code_o
);
  import fcsd_pkg::*;

  cmd_t    cmd;
  status_t status;

  fcsd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .last_o        (last_o),
    .no_identity_o (no_identity_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  fcsd_datapath u_datapath (
    .clk_i          (clk_i),
    .principal_id_i (principal_id_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .digit_o        (digit_o),
    .checksum_o     (checksum_o),
    .friend_code_o  (friend_code_o)
  );

endmodule

// ===== verif/tb_friend_code_sha1_digits_unit.sv =====
// Testbench for friend_code_sha1_digits_unit: drives principal ids and checks every
// digit item against a SHA-1 checksum and decimal split computed inside the bench.
// Depends on the RTL top level only.
module tb_friend_code_sha1_digits_unit;

  typedef struct packed {
    logic [3:0]  digit;
    logic        last;
    logic        no_identity;
    logic [6:0]  checksum;
    logic [38:0] friend_code;
  } code_digit_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [31:0] principal_id_i = '0;
  logic        out_ready_i    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [3:0]  digit_o;
  logic        last_o;
  logic        no_identity_o;
  logic [6:0]  checksum_o;
  logic [38:0] friend_code_o;

  logic [31:0] id_queue [$];
  code_digit_t code_digits_q [$];
  int          ids_sent     = 0;
  int          ids_accepted = 0;
  int          mismatches   = 0;
  int          in_gap       = 0;
  int          out_wait     = 0;
  logic        in_taken     = 1'b0;
  logic        out_taken    = 1'b0;

  friend_code_sha1_digits_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .principal_id_i(principal_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digit_o       (digit_o),
    .last_o        (last_o),
    .no_identity_o (no_identity_o),
    .checksum_o    (checksum_o),
    .friend_code_o (friend_code_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [6:0] sha1_checksum(input logic [31:0] id);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = '0;
    w[0]  = {id[7:0], id[15:8], id[23:16], id[31:24]};
    w[1]  = 32'h8000_0000;
    w[15] = 32'd32;
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = 32'h6745_2301;
    b = 32'hEFCD_AB89;
    c = 32'h98BA_DCFE;
    d = 32'h1032_5476;
    e = 32'hC3D2_E1F0;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A82_7999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9_EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1B_BCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62_C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    t = 32'h6745_2301 + a;
    return t[31:25];
  endfunction

  task automatic queue_friend_code(input logic [31:0] id);
    code_digit_t r;
    logic [38:0] rest;
    logic [3:0]  dig [12];
    if (id == '0) begin
      r = '{digit: 4'd0, last: 1'b1, no_identity: 1'b1, checksum: 7'd0, friend_code: 39'd0};
      code_digits_q.push_back(r);
    end else begin
      r.checksum    = sha1_checksum(id);
      r.friend_code = {r.checksum, id};
      r.no_identity = 1'b0;
      rest = r.friend_code;
      for (int i = 11; i >= 0; i--) begin
        dig[i] = 4'(rest % 39'd10);
        rest   = rest / 39'd10;
      end
      for (int i = 0; i < 12; i++) begin
        r.digit = dig[i];
        r.last  = (i == 11);
        code_digits_q.push_back(r);
      end
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_digit();
    code_digit_t w;
    if (code_digits_q.size() == 0) begin
      report("unexpected item, friend_code", friend_code_o, 0);
    end else begin
      w = code_digits_q.pop_front();
      if (digit_o !== w.digit) report("digit", digit_o, w.digit);
      if (last_o !== w.last) report("last", last_o, w.last);
      if (no_identity_o !== w.no_identity) report("no_identity", no_identity_o, w.no_identity);
      if (checksum_o !== w.checksum) report("checksum", checksum_o, w.checksum);
      if (friend_code_o !== w.friend_code) report("friend_code", friend_code_o, w.friend_code);
    end
  endtask

  function automatic int draw_wait();
    if ((ids_accepted / 37) % 4 == 3) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk_i) begin
    in_taken  <= rst_ni && in_valid_i && in_ready_o;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      queue_friend_code(principal_id_i);
      ids_accepted++;
    end
    if (rst_ni && out_valid_o && out_ready_i) check_digit();
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (id_queue.size() > 0) begin
        in_valid_i     <= 1'b1;
        principal_id_i <= id_queue.pop_front();
        in_gap         <= draw_wait();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    int w;
    if (rst_ni) begin
      w = out_taken ? draw_wait() : out_wait;
      if (w > 0) begin
        out_ready_i <= 1'b0;
        out_wait    <= w - 1;
      end else begin
        out_ready_i <= 1'b1;
        out_wait    <= 0;
      end
    end
  end

  task automatic add_id(input logic [31:0] id);
    id_queue.push_back(id);
    ids_sent++;
  endtask

  initial begin
    logic [31:0] id;
    int          pick;
    add_id(32'h0000_0000);
    add_id(32'h0000_0001);
    add_id(32'hFFFF_FFFF);
    add_id(32'h0000_0000);
    add_id(32'h0000_0000);
    add_id(32'h8000_0000);
    add_id(32'h7FFF_FFFF);
    add_id(32'h0000_00FF);
    add_id(32'h0000_FF00);
    add_id(32'h00FF_0000);
    add_id(32'hFF00_0000);
    add_id(32'hAAAA_AAAA);
    add_id(32'h5555_5555);
    add_id(32'h0000_0002);
    add_id(32'd10);
    add_id(32'd999_999_999);
    add_id(32'h1234_5678);
    add_id(32'hFFFF_FFFE);
    for (int i = 0; i < 280; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) id = '0;
      else if (pick < 25) id = $urandom_range(1, 255);
      else if (pick < 35) id = 32'h1 << $urandom_range(0, 31);
      else if (pick < 40) id = ~(32'h1 << $urandom_range(0, 31));
      else id = $urandom();
      add_id(id);
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (ids_accepted == ids_sent);
    wait (code_digits_q.size() == 0);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
